/* rtl/acpad_pkg.sv */
// Shared types and constants for the AC phase-angle dimmer.
package acpad_pkg;

    localparam int SLOPE_W    = 6;
    localparam int OFFSET_W   = 12;
    localparam int WDOG_W     = 16;
    localparam int LEVEL_W    = 8;
    localparam int DELAY_W    = 15;
    localparam int PRESCALE_W = 10;
    localparam int MS_W       = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [PRESCALE_W-1:0] TICKS_PER_MS = 10'd1000;
    localparam logic [MS_W-1:0]       MS_SINCE_MAX = 17'd131071;
    localparam logic [LEVEL_W-1:0]    LEVEL_FULL   = 8'd255;

    localparam logic [SLOPE_W-1:0]  SLOPE_RST  = 6'd30;
    localparam logic [OFFSET_W-1:0] OFFSET_RST = 12'd400;
    localparam logic [WDOG_W-1:0]   WDOG_RST   = 16'd60000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_SLOPE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCHDOG_MS  = 2'd2;

    // Item kinds
    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_MESSAGE = 1'b1;

    typedef struct packed {
        logic                 cmd;
        logic                 zero_cross_level;
        logic [LEVEL_W-1:0]   target_level;
    } item_t;

    typedef struct packed {
        logic                 gate_drive;
        logic [LEVEL_W-1:0]   applied_level;
        logic                 firing_pending;
        logic                 watchdog_tripped;
    } result_t;

    typedef struct packed {
        logic                  wr_en;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

endpackage

/* rtl/acpad_core.sv */
// Dimmer state and single-pass update logic for one tick or message.
module acpad_core
    import acpad_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_wr_t cfg_wr,
    input  logic    item_valid,
    input  item_t   item,
    output result_t result
);

    logic [SLOPE_W-1:0]    slope_reg;
    logic [OFFSET_W-1:0]   offset_reg;
    logic [WDOG_W-1:0]     wdog_reg;

    logic [LEVEL_W-1:0]    target_reg, target_next;
    logic [LEVEL_W-1:0]    applied_reg, applied_next;
    logic                  pending_reg, pending_next;
    logic                  zc_prev_reg, zc_prev_next;
    logic [DELAY_W-1:0]    delay_reg, delay_next;
    logic                  gate_reg, gate_next;
    logic [PRESCALE_W-1:0] prescale_reg, prescale_next;
    logic [MS_W-1:0]       ms_reg, ms_next;
    logic                  tripped;

    logic [13:0]           delay_prod;
    logic [DELAY_W-1:0]    delay_load;

    logic [LEVEL_W-1:0] applied_next_pre;
    logic               pending_pre;
    logic               gate_pre;
    logic [DELAY_W-1:0] delay_pre;

    // Firing delay from the level in effect after any expiry this tick
    assign delay_prod = 14'(slope_reg) * 14'(LEVEL_FULL - applied_next_pre);
    assign delay_load = DELAY_W'(delay_prod) + DELAY_W'(offset_reg);

    // Countdown stage
    always_comb begin
        applied_next_pre = applied_reg;
        pending_pre      = pending_reg;
        gate_pre         = gate_reg;
        delay_pre        = delay_reg;
        if (item.cmd == CMD_TICK && pending_reg) begin
            if (delay_reg != '0) begin
                delay_pre = delay_reg - DELAY_W'(1);
            end
            if (delay_pre == '0) begin
                applied_next_pre = target_reg;
                gate_pre         = (target_reg != '0);
                pending_pre      = 1'b0;
                delay_pre        = '0;
            end
        end
    end

    always_comb begin
        target_next   = target_reg;
        applied_next  = applied_next_pre;
        pending_next  = pending_pre;
        zc_prev_next  = zc_prev_reg;
        delay_next    = delay_pre;
        gate_next     = gate_pre;
        prescale_next = prescale_reg;
        ms_next       = ms_reg;
        tripped       = 1'b0;
        if (item.cmd == CMD_MESSAGE) begin
            target_next   = item.target_level;
            ms_next       = '0;
            prescale_next = '0;
        end else begin
            if (item.zero_cross_level && !zc_prev_reg && !pending_pre) begin
                if (applied_next_pre != '0 && applied_next_pre != LEVEL_FULL &&
                    delay_load != '0) begin
                    gate_next    = 1'b0;
                    pending_next = 1'b1;
                    delay_next   = delay_load;
                end else begin
                    // full, off or zero delay: apply target now
                    applied_next = target_reg;
                    gate_next    = (target_reg != '0);
                    pending_next = 1'b0;
                    delay_next   = '0;
                end
            end
            zc_prev_next = item.zero_cross_level;

            prescale_next = prescale_reg + PRESCALE_W'(1);
            if (prescale_next >= TICKS_PER_MS) begin
                prescale_next = '0;
                if (ms_reg < MS_SINCE_MAX) begin
                    ms_next = ms_reg + MS_W'(1);
                end
            end
            if (target_reg != '0 && ms_next > MS_W'(wdog_reg)) begin
                target_next = '0;
                ms_next     = '0;
                tripped     = 1'b1;
            end
        end
    end

    assign result.gate_drive       = gate_next;
    assign result.applied_level    = applied_next;
    assign result.firing_pending   = pending_next;
    assign result.watchdog_tripped = tripped;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slope_reg    <= SLOPE_RST;
            offset_reg   <= OFFSET_RST;
            wdog_reg     <= WDOG_RST;
            target_reg   <= '0;
            applied_reg  <= '0;
            pending_reg  <= 1'b0;
            zc_prev_reg  <= 1'b0;
            delay_reg    <= '0;
            gate_reg     <= 1'b0;
            prescale_reg <= '0;
            ms_reg       <= '0;
        end else begin
            if (cfg_wr.wr_en) begin
                unique case (cfg_wr.index)
                    CFG_DELAY_SLOPE:  slope_reg  <= cfg_wr.data[SLOPE_W-1:0];
                    CFG_DELAY_OFFSET: offset_reg <= cfg_wr.data[OFFSET_W-1:0];
                    CFG_WATCHDOG_MS:  wdog_reg   <= cfg_wr.data[WDOG_W-1:0];
                    default: ;
                endcase
            end
            if (item_valid) begin
                target_reg   <= target_next;
                applied_reg  <= applied_next;
                pending_reg  <= pending_next;
                zc_prev_reg  <= zc_prev_next;
                delay_reg    <= delay_next;
                gate_reg     <= gate_next;
                prescale_reg <= prescale_next;
                ms_reg       <= ms_next;
            end
        end
    end

endmodule

/* rtl/ac_phase_angle_dimmer_top.sv */
// A request waits in the input register, and its core result is registered for m_tdata.
// Throughput: one request per cycle; a full result register stalls s_tready only if
// the input register is also full and m_tready is low.
// The per-request path is one 6x8 multiply, a 15-bit add and the counter compares.
// Reset (aresetn low, synchronous): both stages empty, gate off, levels and counters zero,
// configuration back to slope 30, offset 400 and watchdog 60000 ms.
module ac_phase_angle_dimmer_top
    import acpad_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // zero_cross_level[0], target_level[8:1]
    input  logic                  s_tuser,   // cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata    // gate_drive[0], applied_level[8:1],
                                             // firing_pending[9], watchdog_tripped[10]
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    logic    advance;
    result_t core_res;
    cfg_wr_t cfg_wr;

    assign cfg_wr.wr_en = cfg_wr_en;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    acpad_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr     (cfg_wr),
        .item_valid (advance),
        .item       (in_item_reg),
        .result     (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.cmd              <= s_tuser;
            in_item_reg.zero_cross_level <= s_tdata[0];
            in_item_reg.target_level     <= s_tdata[8:1];
        end
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_res_reg.watchdog_tripped, out_res_reg.firing_pending,
                       out_res_reg.applied_level, out_res_reg.gate_drive};

`ifndef ASSERT_OFF
    a_gate_not_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(out_res_reg.gate_drive && out_res_reg.firing_pending))
        else $error("gate high while firing delay runs");

    a_gate_needs_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.gate_drive) |-> (out_res_reg.applied_level != '0))
        else $error("gate high with zero applied level");

    a_msg_no_trip: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_item_reg.cmd == CMD_MESSAGE) |-> !core_res.watchdog_tripped)
        else $error("watchdog trip reported on a message");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled with room in the pipeline");
`endif

endmodule

/* bench/ac_phase_angle_dimmer_top_tb.sv */
// Self-checking testbench for the AC phase-angle dimmer: stream stimulus, scoreboard, checks.
module ac_phase_angle_dimmer_top_tb;
    import acpad_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 20;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;

    ac_phase_angle_dimmer_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    class dimmer_scoreboard;
        logic [SLOPE_W-1:0]    slope;
        logic [OFFSET_W-1:0]   offset;
        logic [WDOG_W-1:0]     wdog_limit;
        logic [LEVEL_W-1:0]    target;
        logic [LEVEL_W-1:0]    applied;
        logic                  busy;
        logic                  zc_last;
        logic                  gate;
        logic [DELAY_W-1:0]    countdown;
        logic [PRESCALE_W-1:0] prescale;
        logic [MS_W-1:0]       ms_idle;
        result_t               expected_q[$];
        int errors;
        int n_msg;
        int n_tick;
        int n_fired;
        int n_trip;
        int n_checked;

        function new();
            slope      = SLOPE_RST;
            offset     = OFFSET_RST;
            wdog_limit = WDOG_RST;
            target     = '0;
            applied    = '0;
            busy       = 1'b0;
            zc_last    = 1'b0;
            gate       = 1'b0;
            countdown  = '0;
            prescale   = '0;
            ms_idle    = '0;
            errors     = 0;
            n_msg      = 0;
            n_tick     = 0;
            n_fired    = 0;
            n_trip     = 0;
            n_checked  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            unique case (idx)
                CFG_DELAY_SLOPE:  slope      = data[SLOPE_W-1:0];
                CFG_DELAY_OFFSET: offset     = data[OFFSET_W-1:0];
                CFG_WATCHDOG_MS:  wdog_limit = data[WDOG_W-1:0];
                default: ;
            endcase
        endfunction

        function void latch_target();
            applied   = target;
            gate      = (target != '0);
            busy      = 1'b0;
            countdown = '0;
        endfunction

        function void note_input(item_t it);
            result_t     r;
            int unsigned span;
            r.watchdog_tripped = 1'b0;
            if (it.cmd == CMD_MESSAGE) begin
                n_msg++;
                target   = it.target_level;
                ms_idle  = '0;
                prescale = '0;
            end else begin
                n_tick++;
                if (busy) begin
                    if (countdown != '0)
                        countdown--;
                    if (countdown == '0) begin
                        latch_target();
                        n_fired++;
                    end
                end
                // rising edge only counts while idle; full and zero levels apply at once
                if (it.zero_cross_level && !zc_last && !busy) begin
                    if (applied != '0 && applied != LEVEL_FULL) begin
                        span = 32'(slope) * (32'(LEVEL_FULL) - 32'(applied)) + 32'(offset);
                        gate      = 1'b0;
                        busy      = 1'b1;
                        countdown = span[DELAY_W-1:0];
                        if (countdown == '0) begin
                            latch_target();
                            n_fired++;
                        end
                    end else begin
                        latch_target();
                    end
                end
                zc_last  = it.zero_cross_level;
                prescale = prescale + 1'b1;
                if (prescale >= TICKS_PER_MS) begin
                    prescale = '0;
                    if (ms_idle != MS_SINCE_MAX)
                        ms_idle++;
                end
                if (target != '0 && ms_idle > MS_W'(wdog_limit)) begin
                    target  = '0;
                    ms_idle = '0;
                    r.watchdog_tripped = 1'b1;
                    n_trip++;
                end
            end
            r.gate_drive     = gate;
            r.applied_level  = applied;
            r.firing_pending = busy;
            expected_q.push_back(r);
        endfunction

        function void report(string field, int want, int got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        endfunction

        function void check_result(logic [15:0] d);
            result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result %h expected none actual one", $time, d);
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            if (d[0] !== want.gate_drive)
                report("gate_drive", want.gate_drive, d[0]);
            if (d[8:1] !== want.applied_level)
                report("applied_level", want.applied_level, d[8:1]);
            if (d[9] !== want.firing_pending)
                report("firing_pending", want.firing_pending, d[9]);
            if (d[10] !== want.watchdog_tripped)
                report("watchdog_tripped", want.watchdog_tripped, d[10]);
        endfunction
    endclass

    dimmer_scoreboard board;
    int               burst_left = 0;
    logic [11:0]      rx_cycle   = '0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: rotate through always ready, random, sparse and square-wave stalls
    always @(posedge aclk) begin
        rx_cycle++;
        case (rx_cycle[11:10])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    m_tready <= (rx_cycle[1:0] == 2'd0);
            default: m_tready <= rx_cycle[3];
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata);
    end

    task automatic send_item(logic cmd, logic zc, logic [LEVEL_W-1:0] lvl);
        item_t it;
        int    gap;
        it.cmd              = cmd;
        it.zero_cross_level = zc;
        it.target_level     = lvl;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600)
                                                     : $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, lvl, zc};
        do @(posedge aclk); while (!s_tready);
        board.note_input(it);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.expected_q.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] slope_data,
                             logic [CFG_DATA_W-1:0] offset_data,
                             logic [CFG_DATA_W-1:0] wdog_data,
                             bit poke_unused);
        logic [CFG_DATA_W-1:0] vals[3];
        logic [CFG_DATA_W-1:0] junk;
        vals[CFG_DELAY_SLOPE]  = slope_data;
        vals[CFG_DELAY_OFFSET] = offset_data;
        vals[CFG_WATCHDOG_MS]  = wdog_data;
        drain();
        for (int i = CFG_DELAY_SLOPE; i <= CFG_WATCHDOG_MS; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge aclk);
            board.set_reg(CFG_IDX_W'(i), vals[i]);
        end
        if (poke_unused) begin
            junk = CFG_DATA_W'($urandom);
            cfg_index <= CFG_UNUSED;
            cfg_data  <= junk;
            @(posedge aclk);
            board.set_reg(CFG_UNUSED, junk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [LEVEL_W-1:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return LEVEL_FULL;
            2:       return 8'd1;
            3:       return LEVEL_FULL - 8'd1;
            default: return LEVEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    // one mains half cycle per pass: optional random burst, optional level change, low stretch, high stretch
    task automatic run_random(int halfcycles, int msg_pct);
        int unsigned stretch_max;
        int unsigned lo;
        int unsigned hi;
        int unsigned n;
        stretch_max = (32'(board.slope) * 254 + 32'(board.offset)) / 2 + 8;
        // keep half cycles short; long delays run on across several of them
        if (stretch_max > 24)
            stretch_max = 24;
        for (int h = 0; h < halfcycles; h++) begin
            if ($urandom_range(0, 99) < 10) begin
                n = $urandom_range(2, 10);
                repeat (n)
                    send_item(($urandom_range(0, 3) == 0) ? CMD_MESSAGE : CMD_TICK,
                              1'($urandom_range(0, 1)), LEVEL_W'($urandom_range(0, 255)));
            end
            lo = $urandom_range(1, stretch_max);
            hi = $urandom_range(1, stretch_max);
            if ($urandom_range(0, 99) < msg_pct)
                send_item(CMD_MESSAGE, 1'($urandom_range(0, 1)), pick_level());
            repeat (lo)
                send_item(CMD_TICK, 1'b0, LEVEL_W'($urandom_range(0, 255)));
            // change the target while a firing delay may be running
            if ($urandom_range(0, 99) < 10)
                send_item(CMD_MESSAGE, 1'($urandom_range(0, 1)), pick_level());
            repeat (hi)
                send_item(CMD_TICK, 1'b1, LEVEL_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        board = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero delay: full, zero and mid levels, ignored fields set
        configure(16'd0, 16'd0, 16'd0, 1'b1);
        send_item(CMD_MESSAGE, 1'b1, LEVEL_FULL);
        send_item(CMD_TICK,    1'b1, 8'hFF);
        send_item(CMD_TICK,    1'b0, 8'h00);
        send_item(CMD_MESSAGE, 1'b0, 8'd128);
        send_item(CMD_TICK,    1'b1, 8'hAA);
        send_item(CMD_TICK,    1'b0, 8'h55);
        send_item(CMD_MESSAGE, 1'b1, 8'd1);
        send_item(CMD_TICK,    1'b1, 8'h00);
        send_item(CMD_TICK,    1'b1, 8'hFF);
        send_item(CMD_TICK,    1'b0, 8'h00);
        send_item(CMD_MESSAGE, 1'b0, 8'd0);
        send_item(CMD_TICK,    1'b1, 8'h00);
        send_item(CMD_TICK,    1'b0, 8'h00);

        // short delay: edge while busy, edge on the expiry tick
        configure(16'd0, 16'd3, 16'd0, 1'b0);
        send_item(CMD_MESSAGE, 1'b0, LEVEL_FULL - 8'd1);
        send_item(CMD_TICK,    1'b1, 8'h00);
        send_item(CMD_TICK,    1'b0, 8'h00);
        send_item(CMD_TICK,    1'b1, 8'h00);
        send_item(CMD_TICK,    1'b0, 8'h00);
        send_item(CMD_TICK,    1'b1, 8'h00);
        send_item(CMD_TICK,    1'b0, 8'h00);
        send_item(CMD_TICK,    1'b1, 8'h00);
        send_item(CMD_TICK,    1'b0, 8'h00);
        send_item(CMD_TICK,    1'b0, 8'h00);
        send_item(CMD_TICK,    1'b1, 8'h00);

        configure(16'd1, 16'd20, 16'd0, 1'b0);
        run_random(8, 20);
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        run_random(1, 50);
        configure(CFG_DATA_W'($urandom) & 16'hFFC3, CFG_DATA_W'($urandom) & 16'hF01F,
                  CFG_DATA_W'($urandom_range(0, 2)), 1'b1);
        run_random(4, 40);
        configure(16'd0, 16'd0, 16'd1, 1'b0);
        run_random(8, 3);
        configure(16'(SLOPE_RST), 16'(OFFSET_RST), 16'(WDOG_RST), 1'b0);
        run_random(2, 50);

        drain();
        repeat (10) @(posedge aclk);
        $display("Sent %0d requests: %0d level messages and %0d ticks, %0d delayed firings,",
                 board.n_msg + board.n_tick, board.n_msg, board.n_tick, board.n_fired);
        $display("%0d watchdog trips, %0d results compared over seven register settings.",
                 board.n_trip, board.n_checked);
        if (board.errors == 0 && board.expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/acpad_pkg.sv
rtl/acpad_core.sv
rtl/ac_phase_angle_dimmer_top.sv
bench/ac_phase_angle_dimmer_top_tb.sv
